// ----- hw/rtl/cbf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_pkg
// Types, constants and helpers shared by the Bezier flattener modules.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int CoordW        = 24;
  localparam int SegW          = 23;
  localparam int TW            = 17;                  // 0 .. 1.0 inclusive
  localparam int OneT          = 65536;
  localparam int MaxCurvePts   = 63;
  localparam int MinStep       = (OneT + MaxCurvePts - 2) / (MaxCurvePts - 1);
  localparam int SegReset      = 256;
  localparam int FifoDepth     = 2;

  localparam logic CMD_MOVE  = 1'b0;
  localparam logic CMD_CURVE = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  // Curve request handed from front to back; point 0 is the start point.
  typedef struct packed {
    logic                    begin_req;
    logic [3:0][CoordW-1:0]  px;
    logic [3:0][CoordW-1:0]  py;
  } job_t;

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    if (s[CoordW] != s[CoordW-1]) begin
      sat_add = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      sat_add = s[CoordW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cbf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_if
// Valid/ready channels: curve commands in, polyline points out.
// ----------------------------------------------------------------------------
interface cbf_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic                       relative;
  logic                       begin_req;
  logic signed [23:0]         ctrl1_x;
  logic signed [23:0]         ctrl1_y;
  logic signed [23:0]         ctrl2_x;
  logic signed [23:0]         ctrl2_y;
  logic signed [23:0]         dest_x;
  logic signed [23:0]         dest_y;

  modport source (output valid, command, relative, begin_req, ctrl1_x, ctrl1_y,
                  ctrl2_x, ctrl2_y, dest_x, dest_y, input ready);
  modport sink   (input valid, command, relative, begin_req, ctrl1_x, ctrl1_y,
                  ctrl2_x, ctrl2_y, dest_x, dest_y, output ready);
endinterface

interface cbf_pt_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic               last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/cbf_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module cbf_fifo (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  cbf_pkg::job_t push_data_i,
  output logic          full_o,
  input  wire           pop_i,
  output cbf_pkg::job_t pop_data_o,
  output logic          empty_o
);
  import cbf_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);

  job_t                  mem_q [FifoDepth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]         cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == (PtrW+1)'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(FifoDepth-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PtrW'(FifoDepth-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cbf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_front
// Accepts commands, resolves relative coordinates, tracks the current point.
// ----------------------------------------------------------------------------
module cbf_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  cbf_cmd_if.sink        cmd,
  output logic           push_o,
  output cbf_pkg::job_t  job_o,
  input  wire            full_i
);
  import cbf_pkg::*;

  coord_t cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  coord_t c1x, c1y, c2x, c2y, dx, dy;
  logic   acc;

  assign cmd.ready = !full_i;
  assign acc       = cmd.valid && !full_i;

  always_comb begin
    c1x = cmd.ctrl1_x;
    c1y = cmd.ctrl1_y;
    c2x = cmd.ctrl2_x;
    c2y = cmd.ctrl2_y;
    dx  = cmd.dest_x;
    dy  = cmd.dest_y;
    if (cmd.relative) begin
      c1x = sat_add(cmd.ctrl1_x, cur_x_q);
      c1y = sat_add(cmd.ctrl1_y, cur_y_q);
      c2x = sat_add(cmd.ctrl2_x, cur_x_q);
      c2y = sat_add(cmd.ctrl2_y, cur_y_q);
      dx  = sat_add(cmd.dest_x, cur_x_q);
      dy  = sat_add(cmd.dest_y, cur_y_q);
    end
    job_o.begin_req = cmd.begin_req;
    job_o.px        = {dx, c2x, c1x, cur_x_q};
    job_o.py        = {dy, c2y, c1y, cur_y_q};
    push_o          = acc && (cmd.command == CMD_CURVE);
    cur_x_d         = acc ? dx : cur_x_q;
    cur_y_d         = acc ? dy : cur_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cbf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_back
// Length estimate, step division and de Casteljau point evaluation.
// ----------------------------------------------------------------------------
module cbf_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [cbf_pkg::SegW-1:0]      seg_len_i,
  input  wire                          empty_i,
  input  cbf_pkg::job_t                job_i,
  output logic                         pop_o,
  cbf_pt_if.source                     pt
);
  import cbf_pkg::*;

  localparam int SqW   = 50;
  localparam int LenW  = 27;
  localparam int DistW = 26;
  localparam int DivW  = SegW + 16;
  localparam int DcW   = $clog2(DivW + 1);
  localparam int ProdW = CoordW + 1 + TW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BEG  = 4'd1;
  localparam logic [3:0] S_SQX  = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]            st_q;
  job_t                  job_q;
  logic [1:0]            e_q;
  logic [SqW-1:0]        sq_q, v_q, r_q, bit_q;
  logic [LenW-1:0]       len_q;
  logic [DivW-1:0]       dvd_q, quo_q;
  logic [DistW-1:0]      rem_q;
  logic [DcW-1:0]        dc_q;
  logic [TW-1:0]         step_q, t_q;
  logic [2:0]            k_q;
  coord_t                wx_q [5];
  coord_t                wy_q [5];
  coord_t                ax_q, ay_q, ptx_q, pty_q;
  logic signed [ProdW-1:0] prx_q, pry_q;
  logic                  ov_q, olast_q;
  coord_t                ox_q, oy_q;

  coord_t                ea_x, ea_y, eb_x, eb_y;
  logic signed [CoordW:0] ddx, ddy;
  logic [CoordW:0]       abx, aby;
  logic [SqW-1:0]        sqa, sqb;
  logic [SqW-1:0]        trial;
  logic [DistW:0]        rsh;
  logic [DistW-1:0]      half_len;
  logic                  out_free;
  logic                  emit;
  coord_t                opa_x, opb_x, opa_y, opb_y;
  logic signed [CoordW:0] dfx, dfy;
  logic signed [ProdW-1:0] mux, muy;
  logic signed [ProdW-1:0] rx, ry;
  logic [TW:0]           t_next;
  logic [LenW-1:0]       len_sum;

  assign out_free      = !ov_q || pt.ready;
  assign emit          = out_free && ((st_q == S_BEG) || (st_q == S_EMIT));
  assign pt.valid      = ov_q;
  assign pt.point_x    = ox_q;
  assign pt.point_y    = oy_q;
  assign pt.last_point = olast_q;
  assign pop_o         = (st_q == S_IDLE) && !empty_i;

  // edge endpoints and absolute differences
  always_comb begin
    ea_x = job_q.px[e_q];
    ea_y = job_q.py[e_q];
    eb_x = job_q.px[e_q + 2'd1];
    eb_y = job_q.py[e_q + 2'd1];
    ddx  = {eb_x[CoordW-1], eb_x} - {ea_x[CoordW-1], ea_x};
    ddy  = {eb_y[CoordW-1], eb_y} - {ea_y[CoordW-1], ea_y};
    abx  = ddx[CoordW] ? (CoordW+1)'(-ddx) : (CoordW+1)'(ddx);
    aby  = ddy[CoordW] ? (CoordW+1)'(-ddy) : (CoordW+1)'(ddy);
    sqa  = abx * abx;
    sqb  = aby * aby;
    trial    = r_q + bit_q;
    half_len = len_q[LenW-1:1];
    rsh      = {rem_q, dvd_q[DivW-1]};
    len_sum  = len_q + LenW'(r_q);
    t_next   = {1'b0, t_q} + {1'b0, step_q};
  end

  // lerp operand selection per de Casteljau step
  always_comb begin
    case (k_q)
      3'd0: begin
        opa_x = job_q.px[0]; opb_x = job_q.px[1];
        opa_y = job_q.py[0]; opb_y = job_q.py[1];
      end
      3'd1: begin
        opa_x = job_q.px[1]; opb_x = job_q.px[2];
        opa_y = job_q.py[1]; opb_y = job_q.py[2];
      end
      3'd2: begin
        opa_x = job_q.px[2]; opb_x = job_q.px[3];
        opa_y = job_q.py[2]; opb_y = job_q.py[3];
      end
      3'd3: begin
        opa_x = wx_q[0]; opb_x = wx_q[1];
        opa_y = wy_q[0]; opb_y = wy_q[1];
      end
      3'd4: begin
        opa_x = wx_q[1]; opb_x = wx_q[2];
        opa_y = wy_q[1]; opb_y = wy_q[2];
      end
      default: begin
        opa_x = wx_q[3]; opb_x = wx_q[4];
        opa_y = wy_q[3]; opb_y = wy_q[4];
      end
    endcase
    // signed difference times unsigned t, full product width
    dfx = {opb_x[CoordW-1], opb_x} - {opa_x[CoordW-1], opa_x};
    dfy = {opb_y[CoordW-1], opb_y} - {opa_y[CoordW-1], opa_y};
    mux = dfx * $signed({1'b0, t_q});
    muy = dfy * $signed({1'b0, t_q});
    rx  = (prx_q + ProdW'(32768)) >>> 16;
    ry  = (pry_q + ProdW'(32768)) >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      if (emit) begin
        ov_q <= 1'b1;
      end else if (pt.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (!empty_i) begin
            st_q <= job_i.begin_req ? S_BEG : S_SQX;
          end
        end
        S_BEG: begin
          if (out_free) begin
            olast_q <= 1'b0;
            st_q    <= S_SQX;
          end
        end
        S_SQX:  st_q <= S_SQY;
        S_SQY:  st_q <= S_SQRT;
        S_SQRT: begin
          if (bit_q == '0) begin
            st_q <= (e_q == 2'd2) ? S_DIV : S_SQX;
          end
        end
        S_DIV: begin
          if (dc_q == DcW'(DivW)) begin
            st_q <= S_MUL;
          end
        end
        S_MUL: st_q <= S_ADD;
        S_ADD: st_q <= (k_q == 3'd5) ? S_EMIT : S_MUL;
        S_EMIT: begin
          if (out_free) begin
            olast_q <= (t_next > (TW+1)'(OneT));
            st_q    <= (t_next > (TW+1)'(OneT)) ? S_IDLE : S_MUL;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        job_q <= job_i;
        e_q   <= '0;
        len_q <= '0;
      end
      S_BEG: begin
        if (out_free) begin
          ox_q <= job_q.px[0];
          oy_q <= job_q.py[0];
        end
      end
      S_SQX: sq_q <= sqa;
      S_SQY: begin
        v_q   <= sq_q + sqb;
        r_q   <= '0;
        bit_q <= SqW'(1) << 48;
      end
      S_SQRT: begin
        if (bit_q == '0) begin
          len_q <= len_sum;
          e_q   <= e_q + 2'd1;
          dvd_q <= {seg_len_i, 16'd0};
          rem_q <= '0;
          quo_q <= '0;
          dc_q  <= '0;
        end else begin
          if (v_q >= trial) begin
            v_q <= v_q - trial;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      S_DIV: begin
        if (dc_q == DcW'(DivW)) begin
          // clamp; a quotient beyond one (zero length too) yields one point
          if (quo_q > DivW'(OneT)) begin
            step_q <= TW'(OneT + 1);
          end else if (quo_q < DivW'(MinStep)) begin
            step_q <= TW'(MinStep);
          end else begin
            step_q <= quo_q[TW-1:0];
          end
          t_q <= '0;
          k_q <= '0;
        end else begin
          dc_q  <= dc_q + 1'b1;
          dvd_q <= dvd_q << 1;
          if (rsh >= {1'b0, half_len}) begin
            rem_q <= DistW'(rsh - {1'b0, half_len});
            quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= rsh[DistW-1:0];
            quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
        end
      end
      S_MUL: begin
        ax_q  <= opa_x;
        ay_q  <= opa_y;
        prx_q <= mux;
        pry_q <= muy;
      end
      S_ADD: begin
        if (k_q == 3'd5) begin
          ptx_q <= ax_q + rx[CoordW-1:0];
          pty_q <= ay_q + ry[CoordW-1:0];
        end else begin
          wx_q[k_q] <= ax_q + rx[CoordW-1:0];
          wy_q[k_q] <= ay_q + ry[CoordW-1:0];
          k_q       <= k_q + 3'd1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ox_q <= ptx_q;
          oy_q <= pty_q;
          t_q  <= t_next[TW-1:0];
          k_q  <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cubic_bezier_flattener.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Flattens cubic Bezier curves into polyline points.
// ----------------------------------------------------------------------------
// A move request only updates the current point and emits nothing. A curve
// request passes a two-entry queue to the back end, which takes the request
// (and first emits the start point when a begin point is requested), then
// handles each of the three control-polygon edges (two squaring steps, 25
// steps of the bit-serial square root and one step to add the edge length),
// runs the bit-serial step divider and then evaluates each point with six
// shared multiply/add lerp steps plus the output load. The front keeps taking
// requests while the queue has room, and the output register holds a point
// while the next one is evaluated.
module cubic_bezier_flattener (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  cbf_cmd_if.sink                  cmd_i,
  cbf_pt_if.source                 pt_o,
  input  wire                      seg_len_we_i,
  input  wire [cbf_pkg::SegW-1:0]  seg_len_wdata_i
);
  import cbf_pkg::*;

  logic [SegW-1:0] seg_len_q;
  logic            push, full, pop, empty;
  job_t            push_job, pop_job;

  // segment length register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q <= SegW'(SegReset);
    end else if (seg_len_we_i) begin
      seg_len_q <= seg_len_wdata_i;
    end
  end

  cbf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd_i),
    .push_o (push),
    .job_o  (push_job),
    .full_i (full)
  );

  cbf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  cbf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seg_len_i (seg_len_q),
    .empty_i   (empty),
    .job_i     (pop_job),
    .pop_o     (pop),
    .pt        (pt_o)
  );

endmodule
`default_nettype wire
